// File: sv/milu_pkg.sv
package milu_pkg;

  // Sequencer states, one-hot.
  localparam int NST = 37;

  typedef enum logic [NST-1:0] {
    ST_LOAD   = 37'd1 << 0,
    ST_R_INIT = 37'd1 << 1,
    ST_R_RD   = 37'd1 << 2,
    ST_R_ACC  = 37'd1 << 3,
    ST_R_CHK  = 37'd1 << 4,
    ST_R_DIV  = 37'd1 << 5,
    ST_C_COL  = 37'd1 << 6,
    ST_C_ROW  = 37'd1 << 7,
    ST_C_LDS  = 37'd1 << 8,
    ST_M_A    = 37'd1 << 9,
    ST_M_B    = 37'd1 << 10,
    ST_M_MUL  = 37'd1 << 11,
    ST_M_SUB  = 37'd1 << 12,
    ST_C_WR   = 37'd1 << 13,
    ST_C_SCR  = 37'd1 << 14,
    ST_C_SWP0 = 37'd1 << 15,
    ST_C_SA   = 37'd1 << 16,
    ST_C_SB   = 37'd1 << 17,
    ST_C_SC   = 37'd1 << 18,
    ST_C_SD   = 37'd1 << 19,
    ST_C_PIV  = 37'd1 << 20,
    ST_C_PV2  = 37'd1 << 21,
    ST_C_DR   = 37'd1 << 22,
    ST_C_DS   = 37'd1 << 23,
    ST_C_DW   = 37'd1 << 24,
    ST_C_NXT  = 37'd1 << 25,
    ST_S_WCI  = 37'd1 << 26,
    ST_F_ROW  = 37'd1 << 27,
    ST_F_MV   = 37'd1 << 28,
    ST_F_WR   = 37'd1 << 29,
    ST_B_ROW  = 37'd1 << 30,
    ST_B_RDD  = 37'd1 << 31,
    ST_B_DS   = 37'd1 << 32,
    ST_B_DW   = 37'd1 << 33,
    ST_E_RD   = 37'd1 << 34,
    ST_E_WT   = 37'd1 << 35,
    ST_S_SING = 37'd1 << 36
  } state_t;

  // Which loop the shared multiply-subtract sequence serves.
  typedef enum logic [2:0] {
    PH_LU   = 3'b001,
    PH_FWD  = 3'b010,
    PH_BACK = 3'b100
  } phase_t;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  // Magnitude of a signed word; the most negative value gives 2^31.
  function automatic logic [31:0] mag(input logic signed [31:0] v);
    mag = v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Signed word from sign and magnitude, saturated.
  function automatic logic signed [31:0] from_mag(input logic neg, input logic [63:0] m);
    logic [31:0] low;
    low = m[31:0];
    if (neg) begin
      if (m >= 64'h8000_0000) from_mag = Q_MIN;
      else from_mag = -low;
    end else begin
      if (m > 64'h7FFF_FFFF) from_mag = Q_MAX;
      else from_mag = low;
    end
  endfunction

  // Saturating subtraction a - b.
  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) sat_sub = d[32] ? Q_MIN : Q_MAX;
    else sat_sub = d[31:0];
  endfunction

endpackage

// File: sv/matrix_inverse_lu_core.sv
// Channel    Signals                                   Direction  Moves
// input      in_valid, in_ready, element_in            in         one matrix element
// output     out_valid, out_ready, element_out,        out        one inverse element
//            singular, last
// config     cfg_write, cfg_data                       in         matrix order
//
// An element request is taken whenever in_valid is high while loading; after the last
// one the block is busy: each multiply-subtract uses the shared multiplier and one
// work-matrix port, and each division uses the bit-serial divider.
// Results leave from the inverse memory, each read in ST_E_RD and handed out in
// ST_E_WT once the output register is free.
// Reset is synchronous; it clears the sequencer, load counters and order (8).
// The last result may wait in the output register while loading restarts.
module matrix_inverse_lu_core
  import milu_pkg::*;
#(
  parameter int MAX_ORDER = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [3:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] element_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] element_out,
  output logic               singular,
  output logic               last
);

  localparam int IW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CW    = $clog2(MAX_ORDER + 1);
  localparam int DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = 33 + FRAC_BITS;
  localparam logic signed [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);

  state_t state;
  phase_t phase;

  logic [3:0]    size_reg;
  logic [CW-1:0] n_ord, nm1;
  logic [CW-1:0] li, lj, i, j, k, kend;
  logic [IW-1:0] imax;
  logic [IW-1:0] ii, jj, kk;
  logic signed [31:0] sum, opa, tmp, piv;
  logic [63:0]   big, prod;
  logic          prod_neg, div_neg;
  logic [30:0]   rscale [MAX_ORDER];
  logic [IW-1:0] pivot  [MAX_ORDER];
  logic signed [31:0] wc [MAX_ORDER];

  logic          out_free;
  logic [IW-1:0] wc_idx, rs_idx;
  logic signed [31:0] wc_rd, bval, mq, sub_val, dq;
  logic [30:0]   rs_rd;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   mul_w, rnd;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic signed [31:0] ram_wdata, rd_data;
  logic          inv_we;
  logic signed [31:0] inv_rd;

  logic          div_start, div_done;
  logic [NW-1:0] div_num, div_quot;
  logic [31:0]   div_den, dx, dy, dden;
  logic signed [31:0] div_x, div_y;

  function automatic logic [AW-1:0] at(input logic [CW-1:0] r, input logic [CW-1:0] c);
    at = AW'(int'(r) * MAX_ORDER + int'(c));
  endfunction

  // Order in use, clamped to the supported range.
  always_comb begin
    if (size_reg == 4'd0) n_ord = CW'(1);
    else if (int'(size_reg) > MAX_ORDER) n_ord = CW'(MAX_ORDER);
    else n_ord = CW'(size_reg);
  end
  assign nm1 = n_ord - 1'b1;

  assign ii = i[IW-1:0];
  assign jj = j[IW-1:0];
  assign kk = k[IW-1:0];

  assign in_ready = (state == ST_LOAD);
  assign out_free = !out_valid || out_ready;

  // Single read ports on the small register files.
  always_comb begin
    case (state)
      ST_F_ROW: wc_idx = pivot[ii];
      ST_M_MUL: wc_idx = kk;
      default:  wc_idx = ii;
    endcase
    rs_idx = (state == ST_C_SD) ? jj : ii;
  end
  assign wc_rd = wc[wc_idx];
  assign rs_rd = rscale[rs_idx];

  // Shared multiplier with rounding and saturating subtraction.
  assign bval = (phase == PH_LU) ? rd_data : wc_rd;
  always_comb begin
    if (state == ST_C_WR) begin
      mul_a = {1'b0, rs_rd};
      mul_b = mag(sum);
    end else begin
      mul_a = mag(opa);
      mul_b = mag(bval);
    end
  end
  assign mul_w   = mul_a * mul_b;
  assign rnd     = prod + (64'd1 << (FRAC_BITS - 1));
  assign mq      = from_mag(prod_neg, rnd >> FRAC_BITS);
  assign sub_val = sat_sub(sum, mq);

  // Divider operands.
  always_comb begin
    div_x = (state == ST_C_DS) ? rd_data : sum;
    div_y = (state == ST_C_DS) ? piv : rd_data;
    dx    = mag(div_x);
    dy    = mag(div_y);
    dden  = (dy == 32'd0) ? 32'd1 : dy;
    if (state == ST_R_CHK) begin
      div_num = NW'(1) << (2 * FRAC_BITS);
      div_den = big[31:0];
    end else begin
      div_num = (NW'(dx) << FRAC_BITS) + NW'(dden >> 1);
      div_den = dden;
    end
    div_start = ((state == ST_R_CHK) && (big != 64'd0)) ||
                (state == ST_C_DS) || (state == ST_B_DS);
  end
  assign dq = from_mag(div_neg, 64'(div_quot));

  // Work-matrix port addressing.
  always_comb begin
    case (state)
      ST_R_RD:  ram_raddr = at(i, j);
      ST_C_ROW: ram_raddr = at(i, j);
      ST_M_A:   ram_raddr = at(i, k);
      ST_M_B:   ram_raddr = at(k, j);
      ST_C_SA:  ram_raddr = at(CW'(imax), k);
      ST_C_SB:  ram_raddr = at(j, k);
      ST_C_PIV: ram_raddr = at(j, j);
      ST_C_DR:  ram_raddr = at(i, j);
      ST_B_RDD: ram_raddr = at(i, i);
      default:  ram_raddr = '0;
    endcase
    ram_we    = 1'b0;
    ram_waddr = at(i, j);
    ram_wdata = sum;
    case (state)
      ST_LOAD: begin
        ram_we    = in_valid;
        ram_waddr = at(li, lj);
        ram_wdata = element_in;
      end
      ST_C_WR: ram_we = 1'b1;
      ST_C_SC: begin
        ram_we    = 1'b1;
        ram_waddr = at(CW'(imax), k);
        ram_wdata = rd_data;
      end
      ST_C_SD: begin
        ram_we    = 1'b1;
        ram_waddr = at(j, k);
        ram_wdata = tmp;
      end
      ST_C_PV2: begin
        ram_we    = (rd_data == 32'sd0);
        ram_waddr = at(j, j);
        ram_wdata = 32'sd1;
      end
      ST_C_DW: begin
        ram_we    = div_done;
        ram_wdata = dq;
      end
      default: ram_we = 1'b0;
    endcase
  end
  assign inv_we = (state == ST_B_DW) && div_done;

  milu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_work (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  milu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_inv (
    .clk   (clk),
    .we    (inv_we),
    .waddr (at(i, j)),
    .wdata (dq),
    .raddr (at(i, j)),
    .rdata (inv_rd)
  );

  milu_div #(.NW(NW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      phase     <= PH_LU;
      size_reg  <= 4'd8;
      li        <= '0;
      lj        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_LOAD: begin
          if (in_valid) begin
            if (lj == nm1) begin
              lj <= '0;
              if (li == nm1) begin
                li    <= '0;
                i     <= '0;
                state <= ST_R_INIT;
              end else begin
                li <= li + 1'b1;
              end
            end else begin
              lj <= lj + 1'b1;
            end
          end
        end
        // Row scales from the largest magnitude of each row.
        ST_R_INIT: begin
          j     <= '0;
          big   <= '0;
          state <= ST_R_RD;
        end
        ST_R_RD: state <= ST_R_ACC;
        ST_R_ACC: begin
          if (64'(mag(rd_data)) > big) big <= 64'(mag(rd_data));
          if (j == nm1) state <= ST_R_CHK;
          else begin
            j     <= j + 1'b1;
            state <= ST_R_RD;
          end
        end
        ST_R_CHK: state <= (big == 64'd0) ? ST_S_SING : ST_R_DIV;
        ST_R_DIV: begin
          if (div_done) begin
            rscale[ii] <= (div_quot > NW'(Q_MAX)) ? 31'h7FFF_FFFF : div_quot[30:0];
            if (i == nm1) begin
              j     <= '0;
              state <= ST_C_COL;
            end else begin
              i     <= i + 1'b1;
              state <= ST_R_INIT;
            end
          end
        end
        // Crout column loop.
        ST_C_COL: begin
          i     <= '0;
          big   <= '0;
          imax  <= jj;
          phase <= PH_LU;
          state <= ST_C_ROW;
        end
        ST_C_ROW: begin
          k     <= '0;
          kend  <= (i < j) ? i : j;
          state <= ST_C_LDS;
        end
        ST_C_LDS: begin
          sum   <= rd_data;
          state <= (kend == '0) ? ST_C_WR : ST_M_A;
        end
        // Shared multiply-subtract step.
        ST_M_A: state <= ST_M_B;
        ST_M_B: begin
          opa   <= rd_data;
          state <= ST_M_MUL;
        end
        ST_M_MUL: begin
          prod     <= mul_w;
          prod_neg <= opa[31] ^ bval[31];
          state    <= ST_M_SUB;
        end
        ST_M_SUB: begin
          sum <= sub_val;
          k   <= k + 1'b1;
          if (CW'(k + 1'b1) == kend) begin
            case (phase)
              PH_LU:   state <= ST_C_WR;
              PH_FWD:  state <= ST_F_WR;
              PH_BACK: state <= ST_B_RDD;
              default: state <= ST_C_WR;
            endcase
          end else begin
            state <= ST_M_A;
          end
        end
        ST_C_WR: begin
          if (i < j) begin
            i     <= i + 1'b1;
            state <= ST_C_ROW;
          end else begin
            prod  <= mul_w;
            state <= ST_C_SCR;
          end
        end
        // Pivot search; ties go to the later row.
        ST_C_SCR: begin
          if (prod >= big) begin
            big  <= prod;
            imax <= ii;
          end
          if (i == nm1) state <= ST_C_SWP0;
          else begin
            i     <= i + 1'b1;
            state <= ST_C_ROW;
          end
        end
        ST_C_SWP0: begin
          k     <= '0;
          state <= (CW'(imax) == j) ? ST_C_PIV : ST_C_SA;
        end
        ST_C_SA: state <= ST_C_SB;
        ST_C_SB: begin
          tmp   <= rd_data;
          state <= ST_C_SC;
        end
        ST_C_SC: state <= ST_C_SD;
        ST_C_SD: begin
          if (k == nm1) begin
            rscale[imax] <= rs_rd;
            state        <= ST_C_PIV;
          end else begin
            k     <= k + 1'b1;
            state <= ST_C_SA;
          end
        end
        ST_C_PIV: begin
          pivot[jj] <= imax;
          state     <= ST_C_PV2;
        end
        ST_C_PV2: begin
          piv   <= (rd_data == 32'sd0) ? 32'sd1 : rd_data;
          i     <= j + 1'b1;
          state <= (j == nm1) ? ST_C_NXT : ST_C_DR;
        end
        ST_C_DR: state <= ST_C_DS;
        ST_C_DS: begin
          div_neg <= rd_data[31] ^ piv[31];
          state   <= ST_C_DW;
        end
        ST_C_DW: begin
          if (div_done) begin
            if (i == nm1) state <= ST_C_NXT;
            else begin
              i     <= i + 1'b1;
              state <= ST_C_DR;
            end
          end
        end
        ST_C_NXT: begin
          if (j == nm1) begin
            j     <= '0;
            state <= ST_S_WCI;
          end else begin
            j     <= j + 1'b1;
            state <= ST_C_COL;
          end
        end
        // Forward substitution on one unit column.
        ST_S_WCI: begin
          for (int m = 0; m < MAX_ORDER; m++) wc[m] <= '0;
          wc[jj] <= ONE_Q;
          i      <= '0;
          phase  <= PH_FWD;
          state  <= ST_F_ROW;
        end
        ST_F_ROW: begin
          sum   <= wc_rd;
          state <= ST_F_MV;
        end
        ST_F_MV: begin
          wc[pivot[ii]] <= wc_rd;
          k             <= '0;
          kend          <= i;
          state         <= (i == '0) ? ST_F_WR : ST_M_A;
        end
        ST_F_WR: begin
          wc[ii] <= sum;
          if (i == nm1) begin
            phase <= PH_BACK;
            state <= ST_B_ROW;
          end else begin
            i     <= i + 1'b1;
            state <= ST_F_ROW;
          end
        end
        // Back substitution.
        ST_B_ROW: begin
          sum   <= wc_rd;
          k     <= i + 1'b1;
          kend  <= n_ord;
          state <= (i == nm1) ? ST_B_RDD : ST_M_A;
        end
        ST_B_RDD: state <= ST_B_DS;
        ST_B_DS: begin
          div_neg <= sum[31] ^ rd_data[31];
          state   <= ST_B_DW;
        end
        ST_B_DW: begin
          if (div_done) begin
            wc[ii] <= dq;
            if (i == '0) begin
              if (j == nm1) begin
                i     <= '0;
                j     <= '0;
                state <= ST_E_RD;
              end else begin
                j     <= j + 1'b1;
                state <= ST_S_WCI;
              end
            end else begin
              i     <= i - 1'b1;
              state <= ST_B_ROW;
            end
          end
        end
        // Emit the inverse row by row.
        ST_E_RD: state <= ST_E_WT;
        ST_E_WT: begin
          if (out_free) begin
            element_out <= inv_rd;
            singular    <= 1'b0;
            last        <= (i == nm1) && (j == nm1);
            out_valid   <= 1'b1;
            if (j == nm1) begin
              j <= '0;
              if (i == nm1) begin
                i     <= '0;
                state <= ST_LOAD;
              end else begin
                i     <= i + 1'b1;
                state <= ST_E_RD;
              end
            end else begin
              j     <= j + 1'b1;
              state <= ST_E_RD;
            end
          end
        end
        ST_S_SING: begin
          if (out_free) begin
            element_out <= '0;
            singular    <= 1'b1;
            last        <= 1'b1;
            out_valid   <= 1'b1;
            state       <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
      // A configuration write also resets the load position.
      if (cfg_write) begin
        size_reg <= cfg_data;
        li       <= '0;
        lj       <= '0;
      end
    end
  end

  // A singular result always closes the run.
  a_sing_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> last)
    else $error("singular result without last");

  // The divider only finishes while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_R_DIV || state == ST_C_DW || state == ST_B_DW))
    else $error("divider finished outside a wait state");

  // The chosen pivot row is never above the current column.
  a_pivot_row: assert property (@(posedge clk) disable iff (rst)
    state == ST_C_PIV |-> (CW'(imax) >= j && CW'(imax) < n_ord))
    else $error("pivot row out of range");

  // Load position stays inside the matrix in use.
  a_load_pos: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> (li < n_ord && lj < n_ord))
    else $error("load position outside matrix");

endmodule

// File: sv/milu_ram.sv
module milu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/milu_div.sv
module milu_div #(
  parameter int NW = 49
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [31:0]   den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [31:0]     rem;
  logic [31:0]     dsr;
  logic [32:0]     trial;
  logic            qbit;

  // One quotient bit per cycle, restoring.
  always_comb begin
    trial = {rem, quot[NW-1]};
    qbit  = (trial >= {1'b0, dsr});
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
      dsr  <= den;
    end else if (busy) begin
      rem  <= qbit ? 32'(trial - {1'b0, dsr}) : trial[31:0];
      quot <= {quot[NW-2:0], qbit};
    end
  end

endmodule
